### rtl/core/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and the escape table of the escape string
// decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChCaret  = 8'h5E;

  localparam logic [7:0] CtrlMask  = 8'h1F;
  localparam logic [7:0] ZeroValue = 8'h80;

  typedef enum logic [2:0] {
    CLS_PLAIN,
    CLS_TERM,
    CLS_CARET,
    CLS_BSLASH,
    CLS_DIGIT
  } cls_e;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_CARET,
    MODE_BSLASH,
    MODE_NUM
  } mode_e;

  typedef struct packed {
    logic       hit;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic [7:0] chr;
    cls_e       cls;
    logic       esc_hit;
    logic [7:0] esc_val;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Named escapes after a backslash.
  function automatic esc_t esc_lookup(input logic [7:0] c);
    esc_t r;
    r.hit = 1'b1;
    case (c)
      8'h65:   r.val = 8'h1B; // e
      8'h45:   r.val = 8'h1B; // E
      8'h5E:   r.val = 8'h5E; // ^
      8'h5C:   r.val = 8'h5C; // backslash
      8'h2C:   r.val = 8'h2C; // comma
      8'h3A:   r.val = 8'h3A; // colon
      8'h6C:   r.val = 8'h0A; // l
      8'h6E:   r.val = 8'h0A; // n
      8'h72:   r.val = 8'h0D; // r
      8'h74:   r.val = 8'h09; // t
      8'h62:   r.val = 8'h08; // b
      8'h66:   r.val = 8'h0C; // f
      8'h73:   r.val = 8'h20; // s
      default: begin
        r.hit = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/esd_front.sv
// ----------------------------------------------------------------------------
// esd_front
// Classifies each incoming character and looks up its named escape.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esd_front (
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    char_in_i,
  input  wire logic          q_full_i,
  output esd_pkg::item_t     item_o,
  output logic               push_o
);

  esd_pkg::esc_t esc;

  always_comb begin
    esc = esd_pkg::esc_lookup(char_in_i);
    item_o.chr     = char_in_i;
    item_o.esc_hit = esc.hit;
    item_o.esc_val = esc.val;
    if (char_in_i == esd_pkg::ChNul || char_in_i == esd_pkg::ChComma) begin
      item_o.cls = esd_pkg::CLS_TERM;
    end else if (char_in_i == esd_pkg::ChCaret) begin
      item_o.cls = esd_pkg::CLS_CARET;
    end else if (char_in_i == esd_pkg::ChBslash) begin
      item_o.cls = esd_pkg::CLS_BSLASH;
    end else if (char_in_i inside {[esd_pkg::ChZero:esd_pkg::ChNine]}) begin
      item_o.cls = esd_pkg::CLS_DIGIT;
    end else begin
      item_o.cls = esd_pkg::CLS_PLAIN;
    end
  end

  assign push_o = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

### rtl/core/esd_queue.sv
// ----------------------------------------------------------------------------
// esd_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esd_queue #(
  parameter int unsigned Depth = esd_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire esd_pkg::item_t item_i,
  input  wire logic           pop_i,
  output esd_pkg::item_t      head_o,
  output esd_pkg::q_stat_t    stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  esd_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

### rtl/core/esd_back.sv
// ----------------------------------------------------------------------------
// esd_back
// Decode state machine and output register. Takes classified characters
// from the queue and emits decoded bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire esd_pkg::item_t head_i,
  input  wire logic           head_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);

  esd_pkg::mode_e mode_q, mode_d;
  logic [9:0]     acc_q, acc_d;
  logic [1:0]     left_q, left_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q;
  logic           out_last_q;

  logic           can_out;
  logic           need_emit;
  logic           consume;
  logic           act;
  logic [7:0]     emit_byte;
  logic           emit_last;
  logic [9:0]     acc_shift;
  logic [1:0]     left_dec;
  logic [7:0]     val_byte;

  assign can_out   = !out_valid_q || !out_stall_i;
  assign acc_shift = {acc_q[6:0], 3'b000} | {6'b0, head_i.chr[3:0]};
  assign left_dec  = left_q - 2'd1;
  assign val_byte  = (acc_q == '0) ? esd_pkg::ZeroValue : acc_q[7:0];

  // Outputs: what the head character emits and whether it is consumed.
  always_comb begin
    need_emit = 1'b0;
    consume   = 1'b1;
    emit_byte = head_i.chr;
    emit_last = 1'b0;
    case (mode_q)
      esd_pkg::MODE_NORMAL: begin
        if (head_i.cls == esd_pkg::CLS_TERM) begin
          need_emit = 1'b1;
          emit_byte = 8'h00;
          emit_last = 1'b1;
        end else if (head_i.cls != esd_pkg::CLS_CARET &&
                     head_i.cls != esd_pkg::CLS_BSLASH) begin
          need_emit = 1'b1;
        end
      end
      esd_pkg::MODE_CARET: begin
        need_emit = 1'b1;
        emit_byte = head_i.chr & esd_pkg::CtrlMask;
      end
      esd_pkg::MODE_BSLASH: begin
        if (head_i.esc_hit) begin
          need_emit = 1'b1;
          emit_byte = head_i.esc_val;
        end else if (head_i.cls != esd_pkg::CLS_DIGIT) begin
          need_emit = 1'b1;
        end
      end
      esd_pkg::MODE_NUM: begin
        if (head_i.cls == esd_pkg::CLS_DIGIT) begin
          need_emit = (left_dec == 2'd0);
          emit_byte = (acc_shift == '0) ? esd_pkg::ZeroValue : acc_shift[7:0];
        end else begin
          need_emit = 1'b1;
          emit_byte = val_byte;
          // Hold a character that gives its own byte; it is decoded again.
          consume   = (head_i.cls == esd_pkg::CLS_CARET ||
                       head_i.cls == esd_pkg::CLS_BSLASH);
        end
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  assign act   = head_valid_i && (!need_emit || can_out);
  assign pop_o = act && consume;

  // Next state.
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    left_d = left_q;
    if (act) begin
      case (mode_q)
        esd_pkg::MODE_NORMAL: begin
          if (head_i.cls == esd_pkg::CLS_CARET) begin
            mode_d = esd_pkg::MODE_CARET;
          end else if (head_i.cls == esd_pkg::CLS_BSLASH) begin
            mode_d = esd_pkg::MODE_BSLASH;
          end
        end
        esd_pkg::MODE_CARET: begin
          mode_d = esd_pkg::MODE_NORMAL;
        end
        esd_pkg::MODE_BSLASH: begin
          mode_d = esd_pkg::MODE_NORMAL;
          if (!head_i.esc_hit && head_i.cls == esd_pkg::CLS_DIGIT) begin
            mode_d = esd_pkg::MODE_NUM;
            acc_d  = {6'b0, head_i.chr[3:0]};
            left_d = 2'd2;
          end
        end
        esd_pkg::MODE_NUM: begin
          if (head_i.cls == esd_pkg::CLS_DIGIT) begin
            if (left_dec == 2'd0) begin
              mode_d = esd_pkg::MODE_NORMAL;
              acc_d  = '0;
              left_d = '0;
            end else begin
              acc_d  = acc_shift;
              left_d = left_dec;
            end
          end else begin
            acc_d  = '0;
            left_d = '0;
            if (head_i.cls == esd_pkg::CLS_CARET) begin
              mode_d = esd_pkg::MODE_CARET;
            end else if (head_i.cls == esd_pkg::CLS_BSLASH) begin
              mode_d = esd_pkg::MODE_BSLASH;
            end else begin
              mode_d = esd_pkg::MODE_NORMAL;
            end
          end
        end
        default: begin
          mode_d = esd_pkg::MODE_NORMAL;
        end
      endcase
    end
  end

  always_comb begin
    if (act && need_emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= esd_pkg::MODE_NORMAL;
      acc_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act && need_emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

### rtl/core/escape_string_decoder_unit.sv
// Decodes a terminal capability string taking one character per beat and
// giving at most one decoded byte per beat. Caret and backslash escapes,
// named escapes and numeric escapes of up to three digits are resolved; a
// comma or NUL ends the string with a zero byte marked last. The sustained
// rate is one character per cycle while the output is not stalled; a
// character ending a numeric escape that gives a byte of its own is decoded
// again after the numeric byte, and the character queue (QDepth entries)
// between classifier and decoder absorbs the repeat; output bytes are registered.
// ----------------------------------------------------------------------------
// escape_string_decoder_unit
// Top level: classifier, character queue and decoder with output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module escape_string_decoder_unit #(
  parameter int unsigned QDepth = esd_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  esd_pkg::item_t   push_item;
  esd_pkg::item_t   head_item;
  esd_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  esd_front u_front (
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .q_full_i   (q_stat.full),
    .item_o     (push_item),
    .push_o     (push)
  );

  esd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  esd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (!q_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  assign in_stall_o = q_stat.full;

`ifndef ASSERT_OFF
  a_stat_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("decoder popped an empty queue");

  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.empty && !push) |=> q_stat.empty)
    else $error("queue filled without a push");

  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (out_byte_o == 8'h00))
    else $error("terminator byte is not zero");
`endif

endmodule

`default_nettype wire
